/* rtl/mhpq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_pkg: shared types and constants of the min-heap priority queue
// Transaction payloads, operation and result codes, sequencer states.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    localparam int CAPACITY  = 64;
    localparam int POS_BITS  = 6;
    localparam int CNT_BITS  = 7;
    localparam int KEY_BITS  = 32;
    localparam int TAG_BITS  = 16;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        FUNC_PUSH   = 2'd0,
        FUNC_POP    = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_NONE   = 2'd3
    } func_e;

    typedef enum logic [2:0] {
        KIND_UPDATE  = 3'd0,
        KIND_POPPED  = 3'd1,
        KIND_REMOVED = 3'd2,
        KIND_FULL    = 3'd3,
        KIND_EMPTY   = 3'd4,
        KIND_BADPOS  = 3'd5
    } kind_e;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TAKE,
        S_HOLE,
        S_UP_CMP,
        S_UP_SWAP,
        S_DN_RD,
        S_DN_CMP,
        S_DN_SWAP,
        S_FLUSH
    } state_e;

    typedef struct packed {
        logic [1:0]          func;
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
        logic [POS_BITS-1:0] position;
    } request_t;

    typedef struct packed {
        logic [2:0]          kind;
        logic [KEY_BITS-1:0] item_key;
        logic [TAG_BITS-1:0] item_tag;
        logic [POS_BITS-1:0] item_position;
        logic [CNT_BITS-1:0] held;
        logic                last;
    } result_t;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
    } item_t;

endpackage
`default_nettype wire

/* rtl/min_heap_priority_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// min_heap_priority_queue: binary min-heap of (key, tag) items, 64 slots
// Push, pop the smallest, remove at a heap position.
// ----------------------------------------------------------------------------
// Usage:
//   Drive request and raise start; the transaction is taken on a clock edge
//   where start is high and busy is low. A two-entry command queue sits in
//   front of the heap sequencer, so busy only rises when both entries wait.
//   Each result appears on result for one cycle with result_valid high; the
//   final result of a transaction carries result.last. The receiver cannot
//   stall the block: results must be taken as they come.
//   Path: a request taken on start waits in the command queue, the sequencer
//   takes it when idle, and each result passes a pending register and then
//   the output register. Sift-up runs S_UP_CMP and S_UP_SWAP per level,
//   sift-down S_DN_RD, S_DN_CMP and S_DN_SWAP per level, bounded by the heap
//   memory's registered reads; full, empty and bad position need no heap pass,
//   and the longest transaction sifts down five levels. One at a time.
//   Reset empties the heap and the queue; slot contents need no clearing.
// ----------------------------------------------------------------------------
module min_heap_priority_queue (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    output logic                busy,
    input  mhpq_pkg::request_t  request,
    output logic                result_valid,
    output mhpq_pkg::result_t   result
);
    import mhpq_pkg::*;

    logic     cmd_valid;
    logic     cmd_pop;
    request_t cmd;

    mhpq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    mhpq_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
`default_nettype wire

/* rtl/mhpq_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_front: command intake
// Accepts requests, drops unused operation codes and queues the rest.
// ----------------------------------------------------------------------------
module mhpq_front (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    output logic                busy,
    input  mhpq_pkg::request_t  request,
    output logic                cmd_valid,
    output mhpq_pkg::request_t  cmd,
    input  wire                 cmd_pop
);
    import mhpq_pkg::*;

    request_t     entry_reg [QUEUE_DEPTH];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   fill_reg, fill_next;
    logic         push;
    logic         pop;

    // classify: only real operations enter the queue
    assign busy      = (fill_reg == 2'(QUEUE_DEPTH));
    assign push      = start && !busy && (func_e'(request.func) != FUNC_NONE);
    assign pop       = cmd_pop && (fill_reg != 2'd0);
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    // advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // hold queued transactions
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= request;
        end
    end

endmodule
`default_nettype wire

/* rtl/mhpq_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_back: heap sequencer
// Holds the heap memory, runs sift-up and sift-down and emits results.
// ----------------------------------------------------------------------------
module mhpq_back (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cmd_valid,
    input  mhpq_pkg::request_t  cmd,
    output logic                cmd_pop,
    output logic                result_valid,
    output mhpq_pkg::result_t   result
);
    import mhpq_pkg::*;

    item_t                mem [CAPACITY];
    item_t                rd_a_reg, rd_b_reg;
    logic                 rd_a_en, rd_b_en, wr_en;
    logic [POS_BITS-1:0]  rd_a_addr, rd_b_addr, wr_addr;
    item_t                wr_data;

    state_e               state_reg, state_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic [CNT_BITS-1:0]  held_reg, held_next;
    logic [POS_BITS-1:0]  i_reg, i_next;
    logic [POS_BITS-1:0]  best_reg, best_next;
    item_t                mov_reg, mov_next;
    item_t                par_reg, par_next;
    logic                 alt_reg, alt_next;
    logic                 is_pop_reg, is_pop_next;
    result_t              pend_reg, pend_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic                 out_valid_reg, out_valid_next;
    result_t              out_reg, out_next;

    logic                 emit;
    logic [2:0]           emit_kind;
    item_t                emit_item;
    logic [POS_BITS-1:0]  emit_pos;
    logic [POS_BITS-1:0]  parent_i;
    logic [CNT_BITS-1:0]  left_i, right_i;
    item_t                cmd_item;
    logic                 mov_lt_l;
    logic                 take_r;

    assign parent_i = POS_BITS'((i_reg - POS_BITS'(1)) >> 1);
    assign left_i   = {i_reg, 1'b1};
    assign right_i  = left_i + CNT_BITS'(1);
    assign cmd_item = '{key: cmd.key, tag: cmd.tag};
    assign mov_lt_l = mov_reg.key < rd_a_reg.key;
    assign take_r   = (right_i < count_reg) &&
                      (rd_b_reg.key < (mov_lt_l ? mov_reg.key : rd_a_reg.key));

    // next state, memory controls and emitted result
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        held_next   = held_reg;
        i_next      = i_reg;
        best_next   = best_reg;
        mov_next    = mov_reg;
        par_next    = par_reg;
        alt_next    = alt_reg;
        is_pop_next = is_pop_reg;
        cmd_pop     = 1'b0;
        rd_a_en     = 1'b0;
        rd_a_addr   = '0;
        rd_b_en     = 1'b0;
        rd_b_addr   = '0;
        wr_en       = 1'b0;
        wr_addr     = i_reg;
        wr_data     = mov_reg;
        emit        = 1'b0;
        emit_kind   = KIND_UPDATE;
        emit_item   = mov_reg;
        emit_pos    = i_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop     = 1'b1;
                    emit        = 1'b1;
                    held_next   = count_reg;
                    is_pop_next = (func_e'(cmd.func) == FUNC_POP);
                    alt_next    = 1'b0;
                    state_next  = S_FLUSH;
                    if (func_e'(cmd.func) == FUNC_PUSH)
                    begin
                        if (count_reg == CNT_BITS'(CAPACITY))
                        begin
                            emit_kind = KIND_FULL;
                            emit_item = cmd_item;
                            emit_pos  = '0;
                        end
                        else
                        begin
                            emit_item  = cmd_item;
                            emit_pos   = count_reg[POS_BITS-1:0];
                            mov_next   = cmd_item;
                            i_next     = count_reg[POS_BITS-1:0];
                            count_next = count_reg + CNT_BITS'(1);
                            held_next  = count_reg + CNT_BITS'(1);
                            if (count_reg == '0)
                            begin
                                wr_en   = 1'b1;
                                wr_addr = '0;
                                wr_data = cmd_item;
                            end
                            else
                            begin
                                rd_a_en    = 1'b1;
                                rd_a_addr  = POS_BITS'((count_reg - CNT_BITS'(1)) >> 1);
                                state_next = S_UP_CMP;
                            end
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        emit_kind = KIND_EMPTY;
                        emit_item = '0;
                        emit_pos  = '0;
                    end
                    else if ((func_e'(cmd.func) == FUNC_REMOVE) &&
                             ({1'b0, cmd.position} >= count_reg))
                    begin
                        emit_kind = KIND_BADPOS;
                        emit_item = '0;
                        emit_pos  = cmd.position;
                    end
                    else
                    begin
                        emit       = 1'b0;
                        rd_a_en    = 1'b1;
                        rd_a_addr  = is_pop_next ? '0 : cmd.position;
                        rd_b_en    = 1'b1;
                        rd_b_addr  = POS_BITS'(count_reg - CNT_BITS'(1));
                        i_next     = is_pop_next ? '0 : cmd.position;
                        count_next = count_reg - CNT_BITS'(1);
                        held_next  = count_reg - CNT_BITS'(1);
                        state_next = S_TAKE;
                    end
                end
            end

            // report the departing item, pick up the last one
            S_TAKE:
            begin
                emit       = 1'b1;
                emit_kind  = is_pop_reg ? KIND_POPPED : KIND_REMOVED;
                emit_item  = rd_a_reg;
                mov_next   = rd_b_reg;
                state_next = ({1'b0, i_reg} == count_reg) ? S_FLUSH : S_HOLE;
            end

            // last item now fills the hole
            S_HOLE:
            begin
                emit = 1'b1;
                if (i_reg == '0)
                begin
                    state_next = S_DN_RD;
                end
                else
                begin
                    rd_a_en    = 1'b1;
                    rd_a_addr  = parent_i;
                    alt_next   = 1'b1;
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                if (mov_reg.key < rd_a_reg.key)
                begin
                    emit       = 1'b1;
                    emit_pos   = parent_i;
                    wr_en      = 1'b1;
                    wr_data    = rd_a_reg;
                    par_next   = rd_a_reg;
                    best_next  = i_reg;
                    i_next     = parent_i;
                    alt_next   = 1'b0;
                    state_next = S_UP_SWAP;
                end
                else if (alt_reg)
                begin
                    alt_next   = 1'b0;
                    state_next = S_DN_RD;
                end
                else
                begin
                    wr_en      = 1'b1;
                    state_next = S_FLUSH;
                end
            end

            S_UP_SWAP:
            begin
                emit      = 1'b1;
                emit_item = par_reg;
                emit_pos  = best_reg;
                if (i_reg == '0)
                begin
                    wr_en      = 1'b1;
                    state_next = S_FLUSH;
                end
                else
                begin
                    rd_a_en    = 1'b1;
                    rd_a_addr  = parent_i;
                    state_next = S_UP_CMP;
                end
            end

            S_DN_RD:
            begin
                if (left_i >= count_reg)
                begin
                    wr_en      = 1'b1;
                    state_next = S_FLUSH;
                end
                else
                begin
                    rd_a_en    = 1'b1;
                    rd_a_addr  = left_i[POS_BITS-1:0];
                    rd_b_en    = 1'b1;
                    rd_b_addr  = right_i[POS_BITS-1:0];
                    state_next = S_DN_CMP;
                end
            end

            S_DN_CMP:
            begin
                if (take_r || !mov_lt_l)
                begin
                    emit       = 1'b1;
                    emit_item  = take_r ? rd_b_reg : rd_a_reg;
                    wr_en      = 1'b1;
                    wr_data    = emit_item;
                    best_next  = take_r ? right_i[POS_BITS-1:0] : left_i[POS_BITS-1:0];
                    state_next = S_DN_SWAP;
                end
                else
                begin
                    wr_en      = 1'b1;
                    state_next = S_FLUSH;
                end
            end

            S_DN_SWAP:
            begin
                emit       = 1'b1;
                emit_pos   = best_reg;
                i_next     = best_reg;
                state_next = S_DN_RD;
            end

            S_FLUSH:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // pending result goes out once the next one or the end is known
    always_comb
    begin
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = 1'b0;
        out_next        = pend_reg;
        out_next.held   = held_reg;
        out_next.last   = 1'b0;
        if (state_reg == S_FLUSH)
        begin
            out_valid_next  = 1'b1;
            out_next.last   = 1'b1;
            pend_valid_next = 1'b0;
        end
        else if (emit)
        begin
            out_valid_next          = pend_valid_reg;
            pend_valid_next         = 1'b1;
            pend_next.kind          = emit_kind;
            pend_next.item_key      = emit_item.key;
            pend_next.item_tag      = emit_item.tag;
            pend_next.item_position = emit_pos;
            pend_next.held          = '0;
            pend_next.last          = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            alt_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            alt_reg        <= alt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        held_reg   <= held_next;
        i_reg      <= i_next;
        best_reg   <= best_next;
        mov_reg    <= mov_next;
        par_reg    <= par_next;
        is_pop_reg <= is_pop_next;
        pend_reg   <= pend_next;
        out_reg    <= out_next;
    end

    // heap memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_a_en)
        begin
            rd_a_reg <= mem[rd_a_addr];
        end
        if (rd_b_en)
        begin
            rd_b_reg <= mem[rd_b_addr];
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule
`default_nettype wire

/* rtl/mhpq_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_checker: port-level checks of the heap queue
// Result consistency rules, bound to the top level.
// ----------------------------------------------------------------------------
module mhpq_checker (
    input wire                 clk,
    input wire                 rst_n,
    input wire                 result_valid,
    input mhpq_pkg::result_t   result
);
    import mhpq_pkg::*;

    // held never exceeds capacity
    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.held <= 7'(CAPACITY)))
        else $error("held above capacity");

    // a full push is a single-result transaction on a full heap
    a_full_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.kind == KIND_FULL)) |->
            (result.last && (result.held == 7'(CAPACITY))))
        else $error("full result malformed");

    // empty reports only on an empty heap and ends the transaction
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.kind == KIND_EMPTY)) |->
            (result.last && (result.held == '0)))
        else $error("empty result malformed");

    // bad position lies at or beyond the item count
    a_badpos: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.kind == KIND_BADPOS)) |->
            (result.last && ({1'b0, result.item_position} >= result.held)))
        else $error("bad position result malformed");

endmodule

bind min_heap_priority_queue mhpq_checker u_mhpq_checker (.*);
`default_nettype wire
